### sv/mtbg_pkg.sv
// package for the metronome tone-burst generator
// sequencer states, register indexes, divider request/response types, sine constants
// no dependencies
package mtbg_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_LEN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_LEN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMPLITUDE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE     = 3'd6;

    localparam logic [CNT_W-1:0] DIV_MOD_STEPS = 6'd32;
    localparam logic [CNT_W-1:0] DIV_ENV_STEPS = 6'd16;

    localparam logic [15:0] AMP_FULL = 16'd32768;

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_W,
        ST_LOC_MUL,
        ST_LOC_PH,
        ST_CHECK,
        ST_ENV,
        ST_EMUL,
        ST_EDIV,
        ST_EDIV_W,
        ST_SMUL,
        ST_SPROD,
        ST_SOUT,
        ST_ADV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
        logic [23:0]      rem_init;
        logic [31:0]      dividend;
        logic [23:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
        logic [23:0] remainder;
    } div_rsp_t;

endpackage

### sv/mtbg_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on mtbg_pkg (div_req_t, div_rsp_t)
module mtbg_div
    import mtbg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [23:0]      rem_reg, rem_next;
    logic [31:0]      sh_reg, sh_next;
    logic [23:0]      den_reg, den_next;

    logic [24:0] trial_w;
    logic [24:0] diff_w;
    logic        ge_w;

    assign trial_w = {rem_reg, sh_reg[31]};
    assign diff_w  = trial_w - {1'b0, den_reg};
    assign ge_w    = trial_w >= {1'b0, den_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        den_next   = den_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = req.steps;
            rem_next   = req.rem_init;
            sh_next    = req.dividend;
            den_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = ge_w ? diff_w[23:0] : trial_w[23:0];
            sh_next    = {sh_reg[30:0], ge_w};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = sh_reg;
    assign rsp.remainder = rem_reg;

endmodule

### sv/mtbg_sine_rom.sv
// sine lookup rom with registered read, contents built at elaboration
// depends on mtbg_pkg (pi constants)
module mtbg_sine_rom
    import mtbg_pkg::*;
#(
    parameter int SINE_POINTS = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_BITS    = 12
)
(
    input  logic                          clk,
    input  logic [IDX_BITS-1:0]           addr,
    output logic signed [SAMPLE_BITS-1:0] rd_data
);

    typedef logic signed [SAMPLE_BITS-1:0] tab_t [SINE_POINTS];

    // taylor series in q2.30, x in [0, pi/2], each term truncated
    function automatic longint unsigned sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    function automatic tab_t build_sine();
        tab_t            tab;
        longint unsigned x;
        longint          v;
        longint          top;
        logic            neg;
        top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        for (int k = 0; k < SINE_POINTS; k++)
        begin
            x   = (longint'(k) * TWO_PI_Q30 + SINE_POINTS / 2) / SINE_POINTS;
            neg = 1'b0;
            if (x >= PI_Q30)
            begin
                neg = 1'b1;
                x   = x - PI_Q30;
            end
            if (x > HALF_PI_Q30)
            begin
                x = PI_Q30 - x;
            end
            v = longint'((sin_q30(x) + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS));
            if (v > top)
            begin
                v = top;
            end
            tab[k] = SAMPLE_BITS'(neg ? -v : v);
        end
        return tab;
    endfunction

    localparam tab_t SINE_TAB = build_sine();

    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= SINE_TAB[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/metronome_tone_burst_generator_core.sv
// top level of the metronome tone-burst generator: config registers, sequencer,
// shared multiplier; depends on mtbg_pkg, mtbg_div, mtbg_sine_rom
//
// channel  | handshake                 | payload
// ---------+---------------------------+----------------------------------
// tick     | tick_valid / tick_stall   | rolling, locate, frame_position
// sample   | sample_valid / sample_stall | sample
// config   | cfg_write                 | cfg_index, cfg_data
//
// one tick at a time: a silent tick goes straight to the output, past the tone
// it only advances, a tone hold adds the sine multiply, an attack or decay ramp
// adds a 16-step envelope divide; locate adds a 32-step frame modulo and phase multiply
// asynchronous active-low reset restores register defaults, position and phase zero
// a result waits in the output register under sample_stall while the next tick
// is already taken; the sequencer holds before writing a second result
module metronome_tone_burst_generator_core
    import mtbg_pkg::*;
#(
    parameter int PHASE_BITS  = 24,
    parameter int SINE_POINTS = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          tick_valid,
    output logic                          tick_stall,
    input  logic                          rolling,
    input  logic                          locate,
    input  logic [31:0]                   frame_position,
    output logic                          sample_valid,
    input  logic                          sample_stall,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int IDX_BITS = $clog2(SINE_POINTS);
    localparam int SUM_W    = (PHASE_BITS > 24) ? PHASE_BITS : 24;

    // config registers
    logic [23:0] beat_length_reg;
    logic [23:0] burst_len_reg;
    logic [23:0] rise_len_reg;
    logic [23:0] fall_len_reg;
    logic [23:0] phase_step_reg;
    logic [15:0] max_amplitude_reg;
    logic        sync_mode_reg;

    state_t state_reg, state_next;
    logic [23:0]           position_reg, position_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  sample_valid_reg, sample_valid_next;

    logic [SAMPLE_BITS-1:0] sample_data_reg, sample_data_next;
    logic [SAMPLE_BITS-1:0] result_reg, result_next;
    logic [23:0]            mul_a_reg, mul_a_next;
    logic [23:0]            mul_b_reg, mul_b_next;
    logic [47:0]            prod_reg, prod_next;
    logic [23:0]            den_reg, den_next;
    logic [15:0]            env_reg, env_next;
    logic                   neg_reg, neg_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [SAMPLE_BITS-1:0] sine_w;
    logic [SAMPLE_BITS-1:0]        sine_abs_w;
    logic [SAMPLE_BITS-2:0]        mag_w;
    logic [23:0]                   blen_w;
    logic [15:0]                   amp_w;
    logic [47:0]                   mul_w;
    logic [24:0]                   pos_inc_w;
    logic [24:0]                   decay_end_w;
    logic [SUM_W-1:0]              phase_sum_w;

    mtbg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mtbg_sine_rom #(
        .SINE_POINTS (SINE_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_BITS    (IDX_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .addr    (phase_reg[PHASE_BITS-1 -: IDX_BITS]),
        .rd_data (sine_w)
    );

    assign blen_w      = (beat_length_reg == 24'd0) ? 24'd1 : beat_length_reg;
    assign amp_w       = (max_amplitude_reg > AMP_FULL) ? AMP_FULL : max_amplitude_reg;
    assign mul_w       = 48'(mul_a_reg) * 48'(mul_b_reg);
    assign pos_inc_w   = {1'b0, position_reg} + 25'd1;
    assign decay_end_w = {1'b0, position_reg} + {1'b0, fall_len_reg};
    assign phase_sum_w = SUM_W'(phase_reg) + SUM_W'(phase_step_reg);
    assign sine_abs_w  = sine_w[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sine_w) : SAMPLE_BITS'(sine_w);
    assign mag_w       = prod_reg[15 +: SAMPLE_BITS-1];

    always_comb
    begin
        state_next        = state_reg;
        position_next     = position_reg;
        phase_next        = phase_reg;
        sample_valid_next = sample_valid_reg && sample_stall;
        sample_data_next  = sample_data_reg;
        result_next       = result_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        prod_next         = prod_reg;
        den_next          = den_reg;
        env_next          = env_reg;
        neg_next          = neg_reg;
        div_req           = '0;
        tick_stall        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    if (sync_mode_reg && !rolling)
                    begin
                        result_next = '0;
                        state_next  = ST_DONE;
                    end
                    else if (sync_mode_reg && locate)
                    begin
                        div_req.start    = 1'b1;
                        div_req.steps    = DIV_MOD_STEPS;
                        div_req.rem_init = '0;
                        div_req.dividend = frame_position;
                        div_req.divisor  = blen_w;
                        state_next       = ST_MOD_W;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_MOD_W:
            begin
                if (div_rsp.done)
                begin
                    position_next = div_rsp.remainder;
                    mul_a_next    = div_rsp.remainder;
                    mul_b_next    = phase_step_reg;
                    state_next    = ST_LOC_MUL;
                end
            end
            ST_LOC_MUL:
            begin
                prod_next  = mul_w;
                state_next = ST_LOC_PH;
            end
            ST_LOC_PH:
            begin
                phase_next = prod_reg[PHASE_BITS-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (position_reg >= blen_w)
                begin
                    position_next = '0;
                    phase_next    = '0;
                end
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                if (position_reg >= burst_len_reg)
                begin
                    result_next = '0;
                    state_next  = ST_ADV;
                end
                else if (decay_end_w >= {1'b0, burst_len_reg})
                begin
                    if (fall_len_reg == 24'd0)
                    begin
                        env_next   = '0;
                        state_next = ST_SMUL;
                    end
                    else
                    begin
                        mul_a_next = burst_len_reg - position_reg;
                        mul_b_next = 24'(amp_w);
                        den_next   = fall_len_reg;
                        state_next = ST_EMUL;
                    end
                end
                else if (position_reg < rise_len_reg)
                begin
                    mul_a_next = position_reg;
                    mul_b_next = 24'(amp_w);
                    den_next   = rise_len_reg;
                    state_next = ST_EMUL;
                end
                else
                begin
                    env_next   = amp_w;
                    state_next = ST_SMUL;
                end
            end
            ST_EMUL:
            begin
                prod_next  = mul_w;
                state_next = ST_EDIV;
            end
            ST_EDIV:
            begin
                // quotient stays below 2^16, so the top bits already sit under the divisor
                div_req.start    = 1'b1;
                div_req.steps    = DIV_ENV_STEPS;
                div_req.rem_init = prod_reg[39:16];
                div_req.dividend = {prod_reg[15:0], 16'h0000};
                div_req.divisor  = den_reg;
                state_next       = ST_EDIV_W;
            end
            ST_EDIV_W:
            begin
                if (div_rsp.done)
                begin
                    env_next   = div_rsp.quotient[15:0];
                    state_next = ST_SMUL;
                end
            end
            ST_SMUL:
            begin
                neg_next   = sine_w[SAMPLE_BITS-1];
                mul_a_next = 24'(sine_abs_w[SAMPLE_BITS-2:0]);
                mul_b_next = 24'(env_reg);
                state_next = ST_SPROD;
            end
            ST_SPROD:
            begin
                prod_next  = mul_w;
                state_next = ST_SOUT;
            end
            ST_SOUT:
            begin
                result_next = neg_reg ? SAMPLE_BITS'(-{1'b0, mag_w}) : {1'b0, mag_w};
                state_next  = ST_ADV;
            end
            ST_ADV:
            begin
                if (pos_inc_w >= {1'b0, blen_w})
                begin
                    position_next = '0;
                    phase_next    = '0;
                end
                else
                begin
                    position_next = pos_inc_w[23:0];
                    phase_next    = phase_sum_w[PHASE_BITS-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sample_valid_reg || !sample_stall)
                begin
                    sample_valid_next = 1'b1;
                    sample_data_next  = result_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            position_reg     <= '0;
            phase_reg        <= '0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            position_reg     <= position_next;
            phase_reg        <= phase_next;
            sample_valid_reg <= sample_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_length_reg   <= 24'd24000;
            burst_len_reg     <= 24'd4800;
            rise_len_reg      <= 24'd48;
            fall_len_reg      <= 24'd480;
            phase_step_reg    <= 24'd307582;
            max_amplitude_reg <= 16'd16384;
            sync_mode_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BEAT_LENGTH:   beat_length_reg   <= cfg_data;
                CFG_BURST_LEN:     burst_len_reg     <= cfg_data;
                CFG_RISE_LEN:      rise_len_reg      <= cfg_data;
                CFG_FALL_LEN:      fall_len_reg      <= cfg_data;
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_data;
                CFG_MAX_AMPLITUDE: max_amplitude_reg <= cfg_data[15:0];
                CFG_SYNC_MODE:     sync_mode_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        sample_data_reg <= sample_data_next;
        result_reg      <= result_next;
        mul_a_reg       <= mul_a_next;
        mul_b_reg       <= mul_b_next;
        prod_reg        <= prod_next;
        den_reg         <= den_next;
        env_reg         <= env_next;
        neg_reg         <= neg_next;
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = sample_data_reg;

    a_pos_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENV) |-> (position_reg < blen_w))
        else $error("position not inside beat at envelope step");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_MOD_W || state_reg == ST_EDIV_W))
        else $error("divider finished while sequencer not waiting");

    a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EDIV_W && div_rsp.done) |-> (div_rsp.quotient <= 32'd32768))
        else $error("envelope quotient above full scale");

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");

endmodule
